// ----- design/dlpd_pkg.sv -----
package dlpd_pkg;

    localparam int LENGTH_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF   = 10;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [31:0] MAX_SIZE_RESET = 32'd1048576;
    localparam logic [7:0]  SEPARATOR      = 8'h3A;
    localparam logic [7:0]  DIGIT_ZERO     = 8'h30;
    localparam logic [7:0]  DIGIT_NINE     = 8'h39;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_SEPARATOR = 2'd1;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd2;

    typedef struct packed {
        logic [1:0] error_code;
        logic       empty_message;
        logic       last_of_message;
        logic       first_of_message;
        logic [7:0] payload_byte;
    } t_result;

endpackage

// ----- design/dlpd_front.sv -----
module dlpd_front #(
    parameter int LENGTH_WIDTH = dlpd_pkg::LENGTH_WIDTH_DEF,
    parameter int MAX_DIGITS   = dlpd_pkg::MAX_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [31:0]       i_cfg_wr_data,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_ready,
    output logic              o_push,
    output dlpd_pkg::t_result o_result
);

    localparam logic [1:0] PH_DIGITS  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_HALTED  = 2'd2;

    localparam int DCW = $clog2(MAX_DIGITS + 1);
    localparam int WW  = LENGTH_WIDTH + 5;
    localparam int CW  = (WW > 33) ? WW : 33;

    logic [1:0]              r_phase, n_phase;
    logic [LENGTH_WIDTH-1:0] r_acc, n_acc;
    logic [DCW-1:0]          r_cnt, n_cnt;
    logic [LENGTH_WIDTH-1:0] r_rem, n_rem;
    logic                    r_first, n_first;
    logic [31:0]             r_max;

    logic          accept;
    logic          is_digit;
    logic [CW-1:0] len_w;
    logic [CW-1:0] need_w;
    logic          too_big;
    logic          rem_le1;

    assign accept   = i_valid && i_ready;
    assign is_digit = i_byte inside {[dlpd_pkg::DIGIT_ZERO:dlpd_pkg::DIGIT_NINE]};
    assign len_w    = (CW'(r_acc) << 3) + (CW'(r_acc) << 1) + CW'(i_byte[3:0]);
    assign need_w   = CW'(r_cnt) + CW'(2);
    assign too_big  = (r_cnt == DCW'(MAX_DIGITS))
                   || ((len_w >> LENGTH_WIDTH) != '0)
                   || ((len_w + need_w) > CW'(r_max));
    assign rem_le1  = (r_rem >> 1) == '0;

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_first  = r_first;
        o_push   = 1'b0;
        o_result = '0;
        if (accept) begin
            case (r_phase)
                PH_PAYLOAD: begin
                    o_push                    = 1'b1;
                    o_result.payload_byte     = i_byte;
                    o_result.first_of_message = r_first;
                    o_result.last_of_message  = rem_le1;
                    n_first                   = 1'b0;
                    if (r_rem != '0) begin
                        n_rem = r_rem - 1'b1;
                    end
                    if (rem_le1) begin
                        n_phase = PH_DIGITS;
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_rem   = '0;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        if (too_big) begin
                            n_phase             = PH_HALTED;
                            o_push              = 1'b1;
                            o_result.error_code = dlpd_pkg::ERR_TOO_LARGE;
                        end else begin
                            n_acc = len_w[LENGTH_WIDTH-1:0];
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else if (i_byte == dlpd_pkg::SEPARATOR && r_cnt != '0) begin
                        n_acc = '0;
                        n_cnt = '0;
                        if (r_acc == '0) begin
                            o_push                   = 1'b1;
                            o_result.last_of_message = 1'b1;
                            o_result.empty_message   = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                            n_rem   = r_acc;
                            n_first = 1'b1;
                        end
                    end else begin
                        n_phase             = PH_HALTED;
                        o_push              = 1'b1;
                        o_result.error_code = dlpd_pkg::ERR_SEPARATOR;
                    end
                end
                default: begin
                    // halted: drop every word
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DIGITS;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_rem   <= '0;
            r_first <= 1'b0;
            r_max   <= dlpd_pkg::MAX_SIZE_RESET;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_rem   <= n_rem;
            r_first <= n_first;
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
        end
    end

`ifndef ASSERT_OFF
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> accept)
        else $error("result pushed without an accepted word");
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_rem != '0)
        else $error("payload phase with no bytes remaining");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALTED |=> r_phase == PH_HALTED && !o_push)
        else $error("left halted state before reset");
    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DCW'(MAX_DIGITS))
        else $error("digit count beyond limit");
`endif

endmodule

// ----- design/dlpd_queue.sv -----
module dlpd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dlpd_pkg::t_result i_result,
    output logic              o_ready,
    output logic              o_valid,
    output dlpd_pkg::t_result o_result,
    input  logic              i_pop_ready
);

    localparam int PW = $clog2(dlpd_pkg::QUEUE_DEPTH);
    localparam int NW = $clog2(dlpd_pkg::QUEUE_DEPTH + 1);

    dlpd_pkg::t_result r_mem [dlpd_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [NW-1:0] r_count;
    logic          pop;

    assign o_ready  = r_count != NW'(dlpd_pkg::QUEUE_DEPTH);
    assign o_valid  = r_count != '0;
    assign o_result = r_mem[r_rd_ptr];
    assign pop      = o_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(dlpd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(dlpd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- design/decimal_length_prefix_deframer.sv -----
// A result word enters the result queue when its byte is taken; the master side reads it from that queue.
// Throughput: one byte per cycle while the result queue has room; the digit step (length
// times ten plus digit, then the frame size compare) is the longest path and completes in that cycle.
// A two-word result queue separates the parser from the master side.
// Reset (synchronous, active low): parser back to the length digits, maximum
// frame size 1048576, result queue empty.
module decimal_length_prefix_deframer #(
    parameter int LENGTH_WIDTH = dlpd_pkg::LENGTH_WIDTH_DEF,
    parameter int MAX_DIGITS   = dlpd_pkg::MAX_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
    output logic        m_axis_tlast,   // last_of_message
    output logic [3:0]  m_axis_tuser    // [0] first_of_message, [1] empty_message,
                                        // [3:2] error_code
);

    logic              push;
    dlpd_pkg::t_result push_result;
    dlpd_pkg::t_result out_result;

    dlpd_front #(
        .LENGTH_WIDTH (LENGTH_WIDTH),
        .MAX_DIGITS   (MAX_DIGITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .i_byte        (s_axis_tdata),
        .i_ready       (s_axis_tready),
        .o_push        (push),
        .o_result      (push_result)
    );

    dlpd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_result    (push_result),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_result    (out_result),
        .i_pop_ready (m_axis_tready)
    );

    assign m_axis_tdata = out_result.payload_byte;
    assign m_axis_tlast = out_result.last_of_message;
    assign m_axis_tuser = {out_result.error_code, out_result.empty_message,
                           out_result.first_of_message};

endmodule
